/* design/fgn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_pkg: shared definitions for the fractal gradient noise unit
// Hash constants, fixed-point helpers, micro-op codes, controller/datapath
// command and status types and the micro-op sequences.
// ----------------------------------------------------------------------------
package fgn_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int FRAC_BITS_DEF   = 16;

  // octave index and octave count widths cover the full parameter range (1..16)
  localparam int OCT_W     = 4;
  localparam int OCT_CNT_W = 5;

  localparam int DIVIDEND_W = 64;

  // lattice hash multipliers
  localparam logic [31:0] HASH_SEED_K = 32'h9E3779B9;
  localparam logic [31:0] HASH_X_K    = 32'h85EBCA6B;
  localparam logic [31:0] HASH_Y_K    = 32'hC2B2AE35;
  localparam logic [31:0] HASH_Z_K    = 32'h27D4EB2F;
  localparam logic [31:0] HASH_W_K    = 32'h165667B1;
  localparam logic [31:0] HASH_MIX1_K = 32'h2C1B3C6D;
  localparam logic [31:0] HASH_MIX2_K = 32'h297A2D39;

  localparam logic [31:0] SEED_OCT_STEP = 32'd1013;
  localparam logic [31:0] SEED_POT_STEP = 32'd7919;

  // potential indexes
  localparam logic [1:0] POT_BASE = 2'd0;
  localparam logic [1:0] POT_A    = 2'd1;
  localparam logic [1:0] POT_B    = 2'd2;

  // division result selects
  localparam logic [1:0] SEL_VALUE = 2'd0;
  localparam logic [1:0] SEL_GX    = 2'd1;
  localparam logic [1:0] SEL_GY    = 2'd2;
  localparam logic [1:0] SEL_GZ    = 2'd3;

  // milli-units to fixed point, rounded to nearest
  function automatic longint milli_fx(input longint m, input int frac);
    return ((m << frac) + 500) / 1000;
  endfunction

  // component of one of the edge-midpoint gradients, chosen by a 5-bit index
  function automatic logic signed [1:0] grad_comp(input logic [4:0] idx,
                                                  input logic [1:0] axis);
    logic [1:0] zero;
    logic [1:0] bsel;
    logic [2:0] sb;
    zero = idx[4:3];
    sb   = idx[2:0];
    bsel = (axis < zero) ? axis : axis - 2'd1;
    if (axis == zero) return 2'sd0;
    return sb[bsel] ? -2'sd1 : 2'sd1;
  endfunction

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    if (v > 65'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -65'sh0_8000_0000) return -32'sh8000_0000;
    return 32'(v);
  endfunction

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_PCLR, OP_OCLR,
    OP_POS, OP_TT, OP_T3, OP_A, OP_U, OP_EE, OP_DU,
    OP_HSEED, OP_HC0, OP_HC1, OP_HC2, OP_HC3, OP_HMIX1, OP_HMIX2,
    OP_DOT, OP_W01, OP_W012, OP_WT, OP_VAL,
    OP_GX1, OP_GX2, OP_GX3, OP_GX4,
    OP_GY1, OP_GY2, OP_GY3, OP_GY4,
    OP_GZ1, OP_GZ2, OP_GZ3,
    OP_OACC, OP_DSTART, OP_DSTORE, OP_FIN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [1:0]       axis;
    logic [3:0]       corner;
    logic [OCT_W-1:0] oct;
    logic [1:0]       pot;
    logic [1:0]       sel;
  } cmd_t;

  typedef struct packed {
    logic                 kind;
    logic [OCT_CNT_W-1:0] n_oct;
    logic                 div_done;
  } stat_t;

  localparam int SETUP_LEN  = 7;
  localparam int CORNER_LEN = 23;

  localparam op_t SETUP_SEQ [SETUP_LEN] = '{
    OP_POS, OP_TT, OP_T3, OP_A, OP_U, OP_EE, OP_DU
  };

  localparam op_t CORNER_SEQ [CORNER_LEN] = '{
    OP_HSEED, OP_HC0, OP_HC1, OP_HC2, OP_HC3, OP_HMIX1, OP_HMIX2,
    OP_DOT, OP_W01, OP_W012, OP_WT, OP_VAL,
    OP_GX1, OP_GX2, OP_GX3, OP_GX4,
    OP_GY1, OP_GY2, OP_GY3, OP_GY4,
    OP_GZ1, OP_GZ2, OP_GZ3
  };

endpackage

/* design/fgn_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_if: input and result channels of the noise unit
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fgn_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] evolve_w;
  logic        [31:0] seed;
  logic        [3:0]  octaves;

  modport source (output valid, kind, pos_x, pos_y, pos_z, evolve_w, seed, octaves,
                  input ready);
  modport sink (input valid, kind, pos_x, pos_y, pos_z, evolve_w, seed, octaves,
                output ready);
endinterface

interface fgn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] noise_value;
  logic signed [31:0] comp_x;
  logic signed [31:0] comp_y;
  logic signed [31:0] comp_z;

  modport source (output valid, noise_value, comp_x, comp_y, comp_z, input ready);
  modport sink (input valid, noise_value, comp_x, comp_y, comp_z, output ready);
endinterface

/* design/fgn_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_div: bit-serial rounding divider
// Signed dividend over a small positive divisor, rounded to nearest with ties
// away from zero; one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fgn_div import fgn_pkg::*; #(
  parameter int DVW = MAX_OCTAVES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic        [DVW-1:0]        divisor,
  output logic                         done,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int NW = DIVIDEND_W + 1;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r;
  logic [NW-1:0] nq_r;
  logic [DVW:0]  rem_r;
  logic [DVW-1:0] dvs_r;

  logic [DIVIDEND_W-1:0] mag;
  logic [NW-1:0]         num;
  logic [DVW:0]          rem_sh;
  logic                  ge;

  // magnitude plus half the divisor for rounding
  assign mag    = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(~dividend + 1'b1) : dividend;
  assign num    = {1'b0, mag} + NW'(divisor >> 1);
  assign rem_sh = {rem_r[DVW-1:0], nq_r[NW-1]};
  assign ge     = (rem_sh >= (DVW+1)'(dvs_r));

  // sequence the iterations
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // load operands, then shift one quotient bit in per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DIVIDEND_W-1];
      nq_r  <= num;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      nq_r  <= {nq_r[NW-2:0], ge};
      rem_r <= ge ? rem_sh - (DVW+1)'(dvs_r) : rem_sh;
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(nq_r[DIVIDEND_W-1:0]) : $signed(nq_r[DIVIDEND_W-1:0]);

endmodule

/* design/fgn_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_dp: noise datapath
// Executes one micro-op per cycle: lattice split, fade terms, corner hash,
// corner blend on one shared fixed-point multiplier, octave sums, division.
// ----------------------------------------------------------------------------
module fgn_dp import fgn_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               in_kind,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_evolve_w,
  input  logic        [31:0] in_seed,
  input  logic        [3:0]  in_octaves,
  output logic signed [31:0] out_noise_value,
  output logic signed [31:0] out_comp_x,
  output logic signed [31:0] out_comp_y,
  output logic signed [31:0] out_comp_z
);

  localparam int F   = FRAC_BITS;
  localparam int OW  = F + 8;
  localparam int PR  = 2 * OW;
  localparam int PW  = 34;
  localparam int QW  = PW + MAX_OCTAVES + F;
  localparam int AW  = DIVIDEND_W;
  localparam int DVW = MAX_OCTAVES;

  localparam logic signed [OW-1:0] ONE     = OW'(longint'(1) << F);
  localparam logic signed [OW-1:0] TEN     = OW'(longint'(10) << F);
  localparam logic signed [OW-1:0] FIFTEEN = OW'(longint'(15) << F);
  localparam logic signed [PR-1:0] HALF    = PR'(longint'(1) << (F - 1));

  localparam logic signed [PW-1:0] OFS_A_X = PW'(milli_fx(31416, F));
  localparam logic signed [PW-1:0] OFS_A_Y = PW'(milli_fx(47853, F));
  localparam logic signed [PW-1:0] OFS_A_Z = PW'(milli_fx(12679, F));
  localparam logic signed [PW-1:0] OFS_B_X = PW'(milli_fx(71231, F));
  localparam logic signed [PW-1:0] OFS_B_Y = PW'(milli_fx(5117, F));
  localparam logic signed [PW-1:0] OFS_B_Z = PW'(milli_fx(93402, F));

  localparam logic [OCT_CNT_W-1:0] MAX_N = OCT_CNT_W'(MAX_OCTAVES);

  // latched item
  logic                 kind_r;
  logic signed [31:0]   p0_r [4];
  logic        [31:0]   seed_r;
  logic [OCT_CNT_W-1:0] n_r;

  // per octave lattice terms
  logic        [31:0]   cell_r [4];
  logic signed [OW-1:0] f_r [4];
  logic signed [OW-1:0] u_r [4];
  logic signed [OW-1:0] du_r [4];
  logic signed [OW-1:0] tt_r, t3_r, a_r;

  // per corner terms
  logic        [31:0]   h_r;
  logic signed [OW-1:0] dot_r, m01_r, m012_r, wt_r, ch_r;

  // sums and results
  logic signed [AW-1:0] vo_r, vacc_r, val0_r;
  logic signed [AW-1:0] gk_r [3];
  logic signed [AW-1:0] gacc_r [3];
  logic signed [AW-1:0] gres_r [3][3];
  logic signed [31:0]   noise_r, cx_r, cy_r, cz_r;

  logic [OCT_CNT_W-1:0] n_in;
  logic signed [31:0]   p0a;
  logic signed [PW-1:0] ofs, pb;
  logic signed [QW-1:0] q;
  logic signed [OW-1:0] fa, six_f;
  logic                 o [4];
  logic signed [OW-1:0] w [4];
  logic signed [OW-1:0] dw [4];
  logic signed [OW-1:0] fo [4];
  logic signed [1:0]    gc [4];
  logic signed [AW-1:0] gcw [3];
  logic        [31:0]   hfin;
  logic signed [OW-1:0] dot_c;
  logic signed [OW-1:0] ma, mb, fm;
  logic signed [PR-1:0] prod;
  logic        [31:0]   ha, hb, hp, seedk, pot_seed;
  logic signed [AW-1:0] fm_x;
  logic [OCT_CNT_W-1:0] vsh, gsh;
  logic signed [AW-1:0] dvd, quot;
  logic [DVW:0]         den_sh;
  logic [DVW-1:0]       den;
  logic                 div_done;

  // clamp the octave count
  always_comb begin
    n_in = OCT_CNT_W'(in_octaves);
    if (n_in == '0) n_in = OCT_CNT_W'(1);
    else if (n_in > MAX_N) n_in = MAX_N;
  end

  // offset position of the current potential, scaled to the octave
  always_comb begin
    p0a = p0_r[cmd.axis];
    ofs = '0;
    if (cmd.pot == POT_A) begin
      unique case (cmd.axis)
        2'd0:    ofs = OFS_A_X;
        2'd1:    ofs = OFS_A_Y;
        2'd2:    ofs = OFS_A_Z;
        default: ofs = '0;
      endcase
    end else if (cmd.pot == POT_B) begin
      unique case (cmd.axis)
        2'd0:    ofs = OFS_B_X;
        2'd1:    ofs = OFS_B_Y;
        2'd2:    ofs = OFS_B_Z;
        default: ofs = '0;
      endcase
    end
    pb = PW'(p0a) + ofs;
    q  = QW'(pb) <<< cmd.oct;
  end

  assign fa    = f_r[cmd.axis];
  assign six_f = (fa <<< 2) + (fa <<< 1);

  // corner weights, offsets and gradient
  assign hfin = h_r ^ (h_r >> 15);
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      o[d]  = cmd.corner[d];
      w[d]  = o[d] ? u_r[d] : ONE - u_r[d];
      dw[d] = o[d] ? du_r[d] : -du_r[d];
      fo[d] = o[d] ? f_r[d] - ONE : f_r[d];
      gc[d] = grad_comp(hfin[4:0], 2'(d));
    end
    dot_c = '0;
    for (int d = 0; d < 4; d++) begin
      if (gc[d] == 2'sd1) dot_c = dot_c + fo[d];
      else if (gc[d] == -2'sd1) dot_c = dot_c - fo[d];
    end
    for (int d = 0; d < 3; d++) begin
      if (gc[d] == 2'sd1) gcw[d] = AW'(wt_r);
      else if (gc[d] == -2'sd1) gcw[d] = -AW'(wt_r);
      else gcw[d] = '0;
    end
  end

  // shared fixed-point multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_TT:   begin ma = fa;                       mb = fa;          end
      OP_T3:   begin ma = tt_r;                     mb = fa;          end
      OP_A:    begin ma = fa;                       mb = six_f - FIFTEEN; end
      OP_U:    begin ma = t3_r;                     mb = a_r;         end
      OP_EE:   begin ma = fa - ONE;                 mb = fa - ONE;    end
      OP_DU:   begin ma = (tt_r <<< 5) - (tt_r <<< 1); mb = a_r;      end
      OP_W01:  begin ma = w[0];                     mb = w[1];        end
      OP_W012: begin ma = m01_r;                    mb = w[2];        end
      OP_WT:   begin ma = m012_r;                   mb = w[3];        end
      OP_VAL:  begin ma = wt_r;                     mb = dot_r;       end
      OP_GX1:  begin ma = dw[0];                    mb = w[1];        end
      OP_GY1:  begin ma = w[0];                     mb = dw[1];       end
      OP_GZ1:  begin ma = m01_r;                    mb = dw[2];       end
      OP_GX2, OP_GY2: begin ma = ch_r;              mb = w[2];        end
      OP_GX3, OP_GY3, OP_GZ2: begin ma = ch_r;      mb = w[3];        end
      OP_GX4, OP_GY4, OP_GZ3: begin ma = ch_r;      mb = dot_r;       end
      default: begin ma = '0;                       mb = '0;          end
    endcase
  end

  assign prod = ma * mb + HALF;
  assign fm   = OW'(prod >>> F);
  assign fm_x = AW'(fm);

  // hash multiplier operands
  always_comb begin
    unique case (cmd.pot)
      POT_A:   pot_seed = SEED_POT_STEP;
      POT_B:   pot_seed = SEED_POT_STEP << 1;
      default: pot_seed = '0;
    endcase
    seedk = seed_r + pot_seed + 32'(cmd.oct) * SEED_OCT_STEP;
    ha = '0;
    hb = '0;
    unique case (cmd.op)
      OP_HSEED: begin ha = seedk;                    hb = HASH_SEED_K; end
      OP_HC0:   begin ha = cell_r[0] + 32'(o[0]);    hb = HASH_X_K;    end
      OP_HC1:   begin ha = cell_r[1] + 32'(o[1]);    hb = HASH_Y_K;    end
      OP_HC2:   begin ha = cell_r[2] + 32'(o[2]);    hb = HASH_Z_K;    end
      OP_HC3:   begin ha = cell_r[3] + 32'(o[3]);    hb = HASH_W_K;    end
      OP_HMIX1: begin ha = h_r ^ (h_r >> 15);        hb = HASH_MIX1_K; end
      OP_HMIX2: begin ha = h_r ^ (h_r >> 12);        hb = HASH_MIX2_K; end
      default:  begin ha = '0;                       hb = '0;          end
    endcase
  end

  assign hp = ha * hb;

  // division operands
  assign vsh    = n_r - OCT_CNT_W'(1) - OCT_CNT_W'(cmd.oct);
  assign gsh    = n_r - OCT_CNT_W'(1);
  assign den_sh = (DVW+1)'(1) << n_r;
  assign den    = DVW'(den_sh - (DVW+1)'(1));
  always_comb begin
    unique case (cmd.sel)
      SEL_GX:  dvd = gacc_r[0] <<< gsh;
      SEL_GY:  dvd = gacc_r[1] <<< gsh;
      SEL_GZ:  dvd = gacc_r[2] <<< gsh;
      default: dvd = vacc_r;
    endcase
  end

  fgn_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == OP_DSTART),
    .dividend (dvd),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  // execute the micro-op
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        kind_r  <= in_kind;
        p0_r[0] <= in_pos_x;
        p0_r[1] <= in_pos_y;
        p0_r[2] <= in_pos_z;
        p0_r[3] <= in_evolve_w;
        seed_r  <= in_seed;
        n_r     <= n_in;
      end
      OP_PCLR: begin
        vacc_r <= '0;
        for (int d = 0; d < 3; d++) gacc_r[d] <= '0;
      end
      OP_OCLR: begin
        vo_r <= '0;
        for (int d = 0; d < 3; d++) gk_r[d] <= '0;
      end
      OP_POS: begin
        cell_r[cmd.axis] <= q[F+31:F];
        f_r[cmd.axis]    <= OW'(q[F-1:0]);
      end
      OP_TT:    tt_r <= fm;
      OP_T3:    t3_r <= fm;
      OP_A:     a_r  <= fm + TEN;
      OP_U:     u_r[cmd.axis] <= fm;
      OP_EE:    a_r  <= fm;
      OP_DU:    du_r[cmd.axis] <= fm;
      OP_HSEED: h_r  <= hp;
      OP_HC0, OP_HC1, OP_HC2, OP_HC3: h_r <= h_r ^ hp;
      OP_HMIX1, OP_HMIX2: h_r <= hp;
      OP_DOT:   dot_r  <= dot_c;
      OP_W01:   m01_r  <= fm;
      OP_W012:  m012_r <= fm;
      OP_WT:    wt_r   <= fm;
      OP_VAL:   vo_r   <= vo_r + fm_x;
      OP_GX1, OP_GX2, OP_GX3, OP_GY1, OP_GY2, OP_GY3, OP_GZ1, OP_GZ2: ch_r <= fm;
      OP_GX4:   gk_r[0] <= gk_r[0] + fm_x + gcw[0];
      OP_GY4:   gk_r[1] <= gk_r[1] + fm_x + gcw[1];
      OP_GZ3:   gk_r[2] <= gk_r[2] + fm_x + gcw[2];
      OP_OACC: begin
        vacc_r <= vacc_r + (vo_r <<< vsh);
        for (int d = 0; d < 3; d++) gacc_r[d] <= gacc_r[d] + gk_r[d];
      end
      OP_DSTORE: begin
        if (cmd.sel == SEL_VALUE) begin
          if (cmd.pot == POT_BASE) val0_r <= quot;
        end else begin
          gres_r[cmd.pot][cmd.sel - 2'd1] <= quot;
        end
      end
      OP_FIN: begin
        noise_r <= sat32(65'(val0_r));
        if (!kind_r) begin
          cx_r <= sat32(65'(gres_r[0][0]));
          cy_r <= sat32(65'(gres_r[0][1]));
          cz_r <= sat32(65'(gres_r[0][2]));
        end else begin
          cx_r <= sat32(65'(gres_r[2][1]) - 65'(gres_r[1][2]));
          cy_r <= sat32(65'(gres_r[0][2]) - 65'(gres_r[2][0]));
          cz_r <= sat32(65'(gres_r[1][0]) - 65'(gres_r[0][1]));
        end
      end
      default: ;
    endcase
  end

  assign stat.kind     = kind_r;
  assign stat.n_oct    = n_r;
  assign stat.div_done = div_done;

  assign out_noise_value = noise_r;
  assign out_comp_x      = cx_r;
  assign out_comp_y      = cy_r;
  assign out_comp_z      = cz_r;

endmodule

/* design/fgn_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgn_ctrl: noise unit sequencer
// Walks potentials, octaves, axes, corners and divisions and owns both channel
// handshakes; one micro-op per cycle unless idle or waiting on divider/output.
// ----------------------------------------------------------------------------
module fgn_ctrl import fgn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_PCLR   = 10'b0000000010,
    S_OCLR   = 10'b0000000100,
    S_SETUP  = 10'b0000001000,
    S_CORNER = 10'b0000010000,
    S_OACC   = 10'b0000100000,
    S_DSTART = 10'b0001000000,
    S_DWAIT  = 10'b0010000000,
    S_DSTORE = 10'b0100000000,
    S_FIN    = 10'b1000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [4:0]       step_r, step_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic [3:0]       corner_r, corner_nxt;
  logic [OCT_W-1:0] oct_r, oct_nxt;
  logic [1:0]       pot_r, pot_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic             out_valid_r, out_valid_nxt;
  op_t              op;

  // next state and micro-op
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    axis_nxt      = axis_r;
    corner_nxt    = corner_r;
    oct_nxt       = oct_r;
    pot_nxt       = pot_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          pot_nxt   = POT_BASE;
          state_nxt = S_PCLR;
        end
      end
      S_PCLR: begin
        op        = OP_PCLR;
        oct_nxt   = '0;
        state_nxt = S_OCLR;
      end
      S_OCLR: begin
        op        = OP_OCLR;
        axis_nxt  = '0;
        step_nxt  = '0;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        op = SETUP_SEQ[step_r[2:0]];
        if (step_r == 5'(SETUP_LEN - 1)) begin
          step_nxt = '0;
          if (axis_r == 2'd3) begin
            corner_nxt = '0;
            state_nxt  = S_CORNER;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_CORNER: begin
        op = CORNER_SEQ[step_r];
        if (step_r == 5'(CORNER_LEN - 1)) begin
          step_nxt = '0;
          if (corner_r == 4'hF) state_nxt = S_OACC;
          else corner_nxt = corner_r + 4'd1;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      S_OACC: begin
        op = OP_OACC;
        if (OCT_CNT_W'(oct_r) == stat.n_oct - OCT_CNT_W'(1)) begin
          sel_nxt   = SEL_VALUE;
          state_nxt = S_DSTART;
        end else begin
          oct_nxt   = oct_r + OCT_W'(1);
          state_nxt = S_OCLR;
        end
      end
      S_DSTART: begin
        op        = OP_DSTART;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) state_nxt = S_DSTORE;
      end
      S_DSTORE: begin
        op = OP_DSTORE;
        if (sel_r == SEL_GZ) begin
          if (pot_r == POT_B || !stat.kind) begin
            state_nxt = S_FIN;
          end else begin
            pot_nxt   = pot_r + 2'd1;
            state_nxt = S_PCLR;
          end
        end else begin
          sel_nxt   = sel_r + 2'd1;
          state_nxt = S_DSTART;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          op            = OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      axis_r      <= '0;
      corner_r    <= '0;
      oct_r       <= '0;
      pot_r       <= '0;
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      axis_r      <= axis_nxt;
      corner_r    <= corner_nxt;
      oct_r       <= oct_nxt;
      pot_r       <= pot_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign cmd.op     = op;
  assign cmd.axis   = axis_r;
  assign cmd.corner = corner_r;
  assign cmd.oct    = oct_r;
  assign cmd.pot    = pot_r;
  assign cmd.sel    = sel_r;

endmodule

/* design/fractal_gradient_noise_4d_curl_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_gradient_noise_4d_curl_unit: 4D fractal gradient noise with curl
// Takes a Q16.16 point (x, y, z, w), a seed, an octave count and a mode, and
// returns the normalized noise value with its spatial gradient or the curl.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per point; accepted when valid and ready are high.
//            ready is high only while the unit is idle.
//   out_ch : one result per item, held in an output register until taken.
//   Per octave the unit runs a clear, a setup sequence per axis (four axes),
//   a corner sequence per corner (16 corners) and an accumulate, one micro-op
//   per cycle on a single shared fixed-point multiplier. Each potential then
//   runs four normalizing divisions on a bit-serial divider. Noise mode
//   computes one potential, curl mode three.
//   A stalled receiver keeps the result in place; the next item is accepted
//   and processed meanwhile, and waits to retire until the register is free.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   any pending result.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_4d_curl_unit import fgn_pkg::*; #(
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst_n,
  fgn_in_if.sink      in_ch,
  fgn_out_if.source   out_ch
);

  cmd_t  cmd;
  stat_t stat;

  fgn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  fgn_dp #(
    .MAX_OCTAVES (MAX_OCTAVES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_ch.kind),
    .in_pos_x        (in_ch.pos_x),
    .in_pos_y        (in_ch.pos_y),
    .in_pos_z        (in_ch.pos_z),
    .in_evolve_w     (in_ch.evolve_w),
    .in_seed         (in_ch.seed),
    .in_octaves      (in_ch.octaves),
    .out_noise_value (out_ch.noise_value),
    .out_comp_x      (out_ch.comp_x),
    .out_comp_y      (out_ch.comp_y),
    .out_comp_z      (out_ch.comp_z)
  );

endmodule

/* bench/fractal_gradient_noise_4d_curl_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fractal_gradient_noise_4d_curl_unit_test: self-checking bench for the unit
// Drives points in noise and curl mode through the input channel and checks
// every result field against a fixed-point model of the fractal noise, the
// spatial gradient and the curl, kept inside this bench. Both channels idle
// at random; one phase holds the receiver off long enough to fill the unit.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_4d_curl_unit_test
  import fgn_pkg::*;
();

  localparam int       MAX_OCT    = MAX_OCTAVES_DEF;
  localparam longint   FX_ONE     = 64'sd65536;
  localparam longint   CYCLE_CAP  = 64'd100_000_000;
  localparam int       RANDOM_CNT = 1530;

  typedef longint lvec4_t [4];
  typedef longint lvec3_t [3];

  typedef struct {
    logic               kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] pw;
    logic        [31:0] seed;
    logic        [3:0]  octaves;
  } point_t;

  typedef struct {
    logic signed [31:0] value;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } noise_res_t;

  logic clk;
  logic rst_n;

  fgn_in_if  in_ch();
  fgn_out_if out_ch();

  fractal_gradient_noise_4d_curl_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  noise_res_t pending_results [$];
  int         mismatch_cnt;
  longint     cycle_cnt;
  bit         quiet_phase;
  bit         hold_request;

  // --------------------------------------------------------------------------
  // fixed-point model
  // --------------------------------------------------------------------------
  function automatic longint fx_mul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint round_div(longint a, longint d);
    longint mag;
    longint q;
    mag = (a < 0) ? -a : a;
    q = (mag + d / 2) / d;
    return (a < 0) ? -q : q;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] corner_hash(logic [31:0] c0, logic [31:0] c1,
                                              logic [31:0] c2, logic [31:0] c3,
                                              logic [31:0] seed);
    logic [31:0] h;
    h = seed * HASH_SEED_K;
    h ^= c0 * HASH_X_K;
    h ^= c1 * HASH_Y_K;
    h ^= c2 * HASH_Z_K;
    h ^= c3 * HASH_W_K;
    h ^= h >> 15;
    h = h * HASH_MIX1_K;
    h ^= h >> 12;
    h = h * HASH_MIX2_K;
    h ^= h >> 15;
    return h;
  endfunction

  function automatic longint edge_grad(logic [4:0] idx, int axis);
    int zero_axis;
    int b;
    zero_axis = idx[4:3];
    if (axis == zero_axis) return 0;
    b = (axis < zero_axis) ? axis : axis - 1;
    return idx[b] ? -64'sd1 : 64'sd1;
  endfunction

  function automatic longint smooth(longint t);
    longint t3;
    t3 = fx_mul(fx_mul(t, t), t);
    return fx_mul(t3, fx_mul(t, 6 * t - 15 * FX_ONE) + 10 * FX_ONE);
  endfunction

  function automatic longint smooth_slope(longint t);
    longint e;
    e = t - FX_ONE;
    return fx_mul(30 * fx_mul(t, t), fx_mul(e, e));
  endfunction

  // one octave: value and gradient over the 16 hypercube corners
  function automatic longint octave_sample(lvec4_t q, logic [31:0] seed,
                                           output lvec3_t g);
    logic [31:0] lat_cell [4];
    logic [31:0] c [4];
    longint      fr [4], u [4], du [4], w [4], dw [4], gc [4];
    longint      value, dot, wt;
    logic [63:0] qb;
    logic [31:0] hv;
    logic [4:0]  idx;
    int          o;
    value = 0;
    g[0] = 0; g[1] = 0; g[2] = 0;
    for (int d = 0; d < 4; d++) begin
      qb = q[d];
      lat_cell[d] = qb[47:16];
      fr[d] = {48'd0, qb[15:0]};
      u[d] = smooth(fr[d]);
      du[d] = smooth_slope(fr[d]);
    end
    for (int k = 0; k < 16; k++) begin
      for (int d = 0; d < 4; d++) begin
        o = (k >> d) & 1;
        c[d] = lat_cell[d] + o;
        w[d] = o ? u[d] : FX_ONE - u[d];
        dw[d] = o ? du[d] : -du[d];
      end
      hv = corner_hash(c[0], c[1], c[2], c[3], seed);
      idx = hv[4:0];
      dot = 0;
      for (int d = 0; d < 4; d++) begin
        o = (k >> d) & 1;
        gc[d] = edge_grad(idx, d);
        dot += gc[d] * (fr[d] - (o ? FX_ONE : 0));
      end
      wt = fx_mul(fx_mul(fx_mul(w[0], w[1]), w[2]), w[3]);
      value += fx_mul(wt, dot);
      g[0] += fx_mul(fx_mul(fx_mul(fx_mul(dw[0], w[1]), w[2]), w[3]), dot) + gc[0] * wt;
      g[1] += fx_mul(fx_mul(fx_mul(fx_mul(w[0], dw[1]), w[2]), w[3]), dot) + gc[1] * wt;
      g[2] += fx_mul(fx_mul(fx_mul(fx_mul(w[0], w[1]), dw[2]), w[3]), dot) + gc[2] * wt;
    end
    return value;
  endfunction

  // sum octaves at doubling frequency and halving amplitude, then normalize
  function automatic longint fractal_sum(lvec4_t p, int n, logic [31:0] seed,
                                         output lvec3_t g);
    lvec4_t      q;
    lvec3_t      gk;
    longint      vacc, v, denom;
    longint      gacc [3];
    logic [31:0] oseed;
    vacc = 0;
    gacc = '{0, 0, 0};
    denom = (64'sd1 <<< n) - 1;
    for (int k = 0; k < n; k++) begin
      for (int d = 0; d < 4; d++) q[d] = p[d] * (64'sd1 <<< k);
      oseed = seed + k * SEED_OCT_STEP;
      v = octave_sample(q, oseed, gk);
      vacc += v * (64'sd1 <<< (n - 1 - k));
      for (int d = 0; d < 3; d++) gacc[d] += gk[d];
    end
    for (int d = 0; d < 3; d++) g[d] = round_div(gacc[d] * (64'sd1 <<< (n - 1)), denom);
    return round_div(vacc, denom);
  endfunction

  function automatic longint milli_offset(longint m);
    return ((m <<< 16) + 500) / 1000;
  endfunction

  function automatic noise_res_t noise_curl_predict(point_t pt);
    lvec4_t     p0, p;
    lvec3_t     g0, g1, g2;
    longint     v;
    int         n;
    noise_res_t r;
    n = pt.octaves;
    if (n < 1) n = 1;
    if (n > MAX_OCT) n = MAX_OCT;
    p0[0] = pt.px; p0[1] = pt.py; p0[2] = pt.pz; p0[3] = pt.pw;
    v = fractal_sum(p0, n, pt.seed, g0);
    r.value = clamp32(v);
    if (!pt.kind) begin
      r.cx = clamp32(g0[0]);
      r.cy = clamp32(g0[1]);
      r.cz = clamp32(g0[2]);
      return r;
    end
    // second and third potentials: offset in space and reseeded
    p = p0;
    p[0] = p0[0] + milli_offset(31416);
    p[1] = p0[1] + milli_offset(47853);
    p[2] = p0[2] + milli_offset(12679);
    void'(fractal_sum(p, n, pt.seed + SEED_POT_STEP, g1));
    p[0] = p0[0] + milli_offset(71231);
    p[1] = p0[1] + milli_offset(5117);
    p[2] = p0[2] + milli_offset(93402);
    void'(fractal_sum(p, n, pt.seed + 2 * SEED_POT_STEP, g2));
    r.cx = clamp32(g2[1] - g1[2]);
    r.cy = clamp32(g0[2] - g2[0]);
    r.cz = clamp32(g1[0] - g0[1]);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("fractal_gradient_noise_4d_curl_unit: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stall bursts, one long hold on request
  // --------------------------------------------------------------------------
  initial begin
    int burst;
    int hold_left;
    burst = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 30000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_ch.ready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result check against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    noise_res_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: value %h comp %h %h %h", out_ch.noise_value,
                   out_ch.comp_x, out_ch.comp_y, out_ch.comp_z);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.noise_value !== exp_r.value || out_ch.comp_x !== exp_r.cx ||
            out_ch.comp_y !== exp_r.cy || out_ch.comp_z !== exp_r.cz) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result error: expected %h %h %h %h, got %h %h %h %h",
                     exp_r.value, exp_r.cx, exp_r.cy, exp_r.cz, out_ch.noise_value,
                     out_ch.comp_x, out_ch.comp_y, out_ch.comp_z);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sender
  // --------------------------------------------------------------------------
  // offer one item, with an optional gap first; leave valid high on return
  task automatic send_item(point_t pt);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.kind     <= pt.kind;
    in_ch.pos_x    <= pt.px;
    in_ch.pos_y    <= pt.py;
    in_ch.pos_z    <= pt.pz;
    in_ch.evolve_w <= pt.pw;
    in_ch.seed     <= pt.seed;
    in_ch.octaves  <= pt.octaves;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(noise_curl_predict(pt));
  endtask

  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return {16'($urandom_range(0, 15) - 8), 16'h0000} | 32'($urandom_range(0, 3));
      default: return {16'($urandom_range(0, 65535)), 16'(16'hFFFF - $urandom_range(0, 3))};
    endcase
  endfunction

  // mostly cheap octave counts, a few long or out of range
  function automatic point_t rand_point();
    point_t pt;
    int r;
    pt.kind = 1'($urandom_range(0, 1));
    pt.px = rand_coord();
    pt.py = rand_coord();
    pt.pz = rand_coord();
    pt.pw = rand_coord();
    pt.seed = $urandom();
    r = $urandom_range(0, 99);
    if (r < 60)      pt.octaves = 4'd1;
    else if (r < 85) pt.octaves = 4'd2;
    else if (r < 96) pt.octaves = 4'($urandom_range(3, 4));
    else             pt.octaves = 4'($urandom_range(0, 15));
    if (pt.octaves > 4'd4 && pt.kind) pt.kind = $urandom_range(0, 3) == 0;
    return pt;
  endfunction

  function automatic point_t make_point(logic kind, logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z, logic [31:0] w,
                                        logic [31:0] seed, logic [3:0] oct);
    point_t pt;
    pt.kind = kind; pt.px = x; pt.py = y; pt.pz = z; pt.pw = w;
    pt.seed = seed; pt.octaves = oct;
    return pt;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  // field extremes, lattice points, octave clamping, seed wrap, both modes
  task automatic test_directed_cases();
    send_item(make_point(1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd1));
    send_item(make_point(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 4'd1));
    send_item(make_point(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'hFFFF_FFFF, 4'd1));
    send_item(make_point(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'd0, 4'd1));
    send_item(make_point(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'hFFFF_FFFF, 4'd2));
    send_item(make_point(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'hFFFF_E000, 4'd1));
    // octave count zero acts as one; above the maximum saturates
    send_item(make_point(1'b0, 32'h0001_8000, 32'h0002_4000, 32'hFFFF_C000, 32'h0000_1234,
                         32'h1234_5678, 4'd0));
    send_item(make_point(1'b1, 32'h0001_8000, 32'h0002_4000, 32'hFFFF_C000, 32'h0000_1234,
                         32'h1234_5678, 4'd0));
    send_item(make_point(1'b0, 32'h0001_8000, 32'h0002_4000, 32'hFFFF_C000, 32'h0000_1234,
                         32'h1234_5678, 4'd8));
    send_item(make_point(1'b0, 32'h0001_8000, 32'h0002_4000, 32'hFFFF_C000, 32'h0000_1234,
                         32'h1234_5678, 4'd9));
    send_item(make_point(1'b1, 32'h0001_8000, 32'h0002_4000, 32'hFFFF_C000, 32'h0000_1234,
                         32'h1234_5678, 4'd15));
    // fractions at the cell edges
    send_item(make_point(1'b0, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0001,
                         32'hFFFF_FFFF, 4'd3));
    send_item(make_point(1'b1, 32'h0000_0001, 32'hFFFF_0000, 32'h7FFF_0000, 32'h8000_FFFF,
                         32'h0000_0001, 4'd2));
    send_item(make_point(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC,
                         32'hA5A5_5A5A, 4'd4));
    send_item(make_point(1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333,
                         32'h5A5A_A5A5, 4'd1));
    go_idle();
  endtask

  task automatic test_random_points(int cnt);
    for (int i = 0; i < cnt; i++) send_item(rand_point());
    go_idle();
  endtask

  // receiver holds off while items keep coming, so the input stalls
  task automatic test_output_hold();
    hold_request = 1'b1;
    for (int i = 0; i < 5; i++) send_item(rand_point());
    go_idle();
  endtask

  // sender waits for the unit to empty, then resumes
  task automatic test_drain_pause();
    wait_drained();
    for (int i = 0; i < 5; i++) send_item(rand_point());
    go_idle();
  endtask

  task automatic test_quiet_tail(int cnt);
    quiet_phase = 1'b1;
    for (int i = 0; i < cnt; i++) send_item(rand_point());
    go_idle();
  endtask

  initial begin
    mismatch_cnt = 0;
    cycle_cnt = 0;
    quiet_phase = 1'b0;
    hold_request = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.pos_z = '0;
    in_ch.evolve_w = '0;
    in_ch.seed = '0;
    in_ch.octaves = 4'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_points(RANDOM_CNT - 60);
    test_output_hold();
    test_drain_pause();
    test_quiet_tail(50);

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatch_cnt == 0 && pending_results.size() == 0)
      $display("fractal_gradient_noise_4d_curl_unit: match");
    else
      $display("fractal_gradient_noise_4d_curl_unit: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
design/fgn_pkg.sv
design/fgn_if.sv
design/fgn_div.sv
design/fgn_dp.sv
design/fgn_ctrl.sv
design/fractal_gradient_noise_4d_curl_unit.sv
bench/fractal_gradient_noise_4d_curl_unit_test.sv
